// File: design/smeu_pkg.sv
`timescale 1ns / 1ps
package smeu_pkg;

    localparam logic [7:0] OP_DATA      = 8'd0;
    localparam logic [7:0] OP_HALT      = 8'd1;
    localparam logic [7:0] OP_READ      = 8'd20;
    localparam logic [7:0] OP_WRITE     = 8'd21;
    localparam logic [7:0] OP_ADD       = 8'd100;
    localparam logic [7:0] OP_SUB       = 8'd101;
    localparam logic [7:0] OP_MULT      = 8'd102;
    localparam logic [7:0] OP_DIV       = 8'd103;
    localparam logic [7:0] OP_PWR       = 8'd104;
    localparam logic [7:0] OP_STORE     = 8'd150;
    localparam logic [7:0] OP_LD_INT    = 8'd151;
    localparam logic [7:0] OP_LD_VAR    = 8'd152;
    localparam logic [7:0] OP_JMP_FALSE = 8'd200;
    localparam logic [7:0] OP_GOTO      = 8'd201;
    localparam logic [7:0] OP_LT        = 8'd210;
    localparam logic [7:0] OP_GT        = 8'd211;
    localparam logic [7:0] OP_EQ        = 8'd212;

    localparam logic [2:0] FLT_NONE      = 3'd0;
    localparam logic [2:0] FLT_UNDERFLOW = 3'd1;
    localparam logic [2:0] FLT_OVERFLOW  = 3'd2;
    localparam logic [2:0] FLT_DIV_ZERO  = 3'd3;
    localparam logic [2:0] FLT_BAD_VAR   = 3'd4;
    localparam logic [2:0] FLT_BAD_JUMP  = 3'd5;

    typedef enum logic [1:0] {
        ALU_MUL = 2'd0,
        ALU_DIV = 2'd1,
        ALU_PWR = 2'd2
    } t_alu_op;

    typedef struct packed {
        logic    start;
        t_alu_op op;
    } t_alu_ctl;

endpackage

// File: design/smeu_alu.sv
`timescale 1ns / 1ps
// Shared iterative unit: multiply (shift-add), divide (restoring) and power
// (square and multiply via the same shift-add multiplier). One bit per cycle.
module smeu_alu
    import smeu_pkg::*;
(
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  t_alu_ctl    i_ctl,
    input  logic [31:0] i_a,
    input  logic [31:0] i_b,
    output logic        o_done,
    output logic [31:0] o_result
);

    typedef enum logic [4:0] {
        S_IDLE = 5'b00001,
        S_MUL  = 5'b00010,
        S_DIV  = 5'b00100,
        S_PSEL = 5'b01000,
        S_FIX  = 5'b10000
    } t_state;

    t_state      r_state, n_state;
    t_alu_op     r_op;
    logic [5:0]  r_cnt;
    logic [31:0] r_x;      // multiplicand / dividend magnitude
    logic [31:0] r_y;      // multiplier / divisor magnitude
    logic [31:0] r_acc;    // product / remainder
    logic [31:0] r_q;
    logic [31:0] r_base;
    logic [31:0] r_exp;
    logic [31:0] r_res;
    logic        r_neg;
    logic        r_sq;     // power: 0 -> result*=base, 1 -> base*=base
    logic        r_done;

    logic [32:0] w_rem;
    logic [31:0] w_ma, w_mb;

    assign w_ma  = i_a[31] ? (32'd0 - i_a) : i_a;
    assign w_mb  = i_b[31] ? (32'd0 - i_b) : i_b;
    assign w_rem = {r_acc, r_x[31]} - {1'b0, r_y};

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
            r_done  <= 1'b0;
        end else begin
            r_state <= n_state;
            r_done  <= 1'b0;
            unique case (r_state)
                S_IDLE: begin
                    if (i_ctl.start) begin
                        r_op <= i_ctl.op;
                        r_cnt <= 6'd0;
                        unique case (i_ctl.op)
                            ALU_MUL: begin
                                r_x <= i_a; r_y <= i_b; r_acc <= 32'd0;
                            end
                            ALU_DIV: begin
                                r_x <= w_ma; r_y <= w_mb; r_acc <= 32'd0;
                                r_neg <= i_a[31] ^ i_b[31];
                            end
                            default: begin
                                r_base <= i_a; r_exp <= i_b; r_res <= 32'd1;
                            end
                        endcase
                    end
                end
                S_MUL: begin
                    if (r_y[0]) r_acc <= r_acc + r_x;
                    r_x <= r_x << 1;
                    r_y <= r_y >> 1;
                    r_cnt <= r_cnt + 6'd1;
                    if (r_cnt == 6'd31) begin
                        if (r_op == ALU_MUL) begin
                            r_done <= 1'b1;
                        end else if (r_sq) begin
                            r_base <= r_acc + (r_y[0] ? r_x : 32'd0);
                            r_exp  <= r_exp >> 1;
                        end else begin
                            r_res <= r_acc + (r_y[0] ? r_x : 32'd0);
                        end
                    end
                end
                S_DIV: begin
                    if (!w_rem[32]) begin
                        r_acc <= w_rem[31:0];
                        r_q   <= {r_q[30:0], 1'b1};
                    end else begin
                        r_acc <= {r_acc[30:0], r_x[31]};
                        r_q   <= {r_q[30:0], 1'b0};
                    end
                    r_x <= r_x << 1;
                    r_cnt <= r_cnt + 6'd1;
                end
                S_PSEL: begin
                    r_cnt <= 6'd0;
                    r_acc <= 32'd0;
                    if (r_exp == 32'd0) begin
                        r_done <= 1'b1;
                    end else if (r_exp[0] && !r_sq) begin
                        r_sq <= 1'b0;
                        r_x <= r_res; r_y <= r_base;
                    end else begin
                        r_x <= r_base; r_y <= r_base;
                    end
                end
                S_FIX: begin
                    r_done <= 1'b1;
                end
                default: ;
            endcase
            if (r_state == S_IDLE) r_sq <= 1'b0;
            if (r_state == S_PSEL && r_exp != 32'd0) r_sq <= !(r_exp[0] && !r_sq);
            if (r_state == S_MUL && r_cnt == 6'd31 && r_op == ALU_PWR)
                r_sq <= !r_sq;
        end
    end

    always_comb begin
        n_state = r_state;
        unique case (r_state)
            S_IDLE: if (i_ctl.start) begin
                unique case (i_ctl.op)
                    ALU_MUL: n_state = S_MUL;
                    ALU_DIV: n_state = S_DIV;
                    default: n_state = S_PSEL;
                endcase
            end
            S_MUL: if (r_cnt == 6'd31) n_state = (r_op == ALU_MUL) ? S_IDLE : S_PSEL;
            S_DIV: if (r_cnt == 6'd31) n_state = S_FIX;
            S_PSEL: if (r_exp == 32'd0) n_state = S_IDLE; else n_state = S_MUL;
            S_FIX: n_state = S_IDLE;
            default: n_state = S_IDLE;
        endcase
    end

    always_comb begin
        case (r_op)
            ALU_MUL: o_result = r_acc;
            ALU_DIV: o_result = r_neg ? (32'd0 - r_q) : r_q;
            default: o_result = r_res;
        endcase
    end

    assign o_done = r_done;

    property p_start_idle;
        @(posedge i_clk) disable iff (!i_rst_n) i_ctl.start |-> r_state == S_IDLE;
    endproperty
    a_start_idle: assert property (p_start_idle) else $error("alu start while busy");

    property p_done_idle;
        @(posedge i_clk) disable iff (!i_rst_n) r_done |-> r_state == S_IDLE;
    endproperty
    a_done_idle: assert property (p_done_idle) else $error("alu done while busy");

    property p_onehot;
        @(posedge i_clk) disable iff (!i_rst_n) $onehot(r_state);
    endproperty
    a_onehot: assert property (p_onehot) else $error("alu state not one-hot");

endmodule

// File: design/stack_machine_execute_unit.sv
`timescale 1ns / 1ps
// Channel   Dir  Handshake         Payload
// s_axis    in   tvalid/tready     tdata = op, argument, read_value
// m_axis    out  tvalid/tready     tdata = write_valid..fault
// cfg       in   i_cfg_we          program_length
//
// From input transfer an instruction passes S_RD1, S_RD2, S_EXEC, S_WB on
// a stack write-back, and S_OUT, then S_IDLE; mult, div and power wait in S_ALU
// (power: one multiply pass per squaring and per multiply).
// Stack and variable reads go through registered memories.
// Reset is synchronous, active low; memories are not cleared.
// A held result stalls intake until taken.
module stack_machine_execute_unit
    import smeu_pkg::*;
#(
    parameter int STACK_DEPTH   = 128,
    parameter int VAR_DEPTH     = 64,
    parameter int PROGRAM_DEPTH = 256
) (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_cfg_we,
    input  logic [8:0]  i_cfg_wdata,
    input  logic        s_axis_tvalid,
    output logic        s_axis_tready,
    // [7:0] op, [39:8] argument, [71:40] read_value
    input  logic [71:0] s_axis_tdata,
    output logic        m_axis_tvalid,
    input  logic        m_axis_tready,
    // [0] write_valid, [32:1] write_value, [40:33] next_pc, [41] halted,
    // [49:42] exit_code, [50] finished, [53:51] fault, [55:54] zero
    output logic [55:0] m_axis_tdata
);

    localparam int SW = $clog2(STACK_DEPTH + 1);
    localparam int SA = $clog2(STACK_DEPTH);
    localparam int VA = (VAR_DEPTH > 1) ? $clog2(VAR_DEPTH) : 1;
    localparam int VW = $clog2(VAR_DEPTH + 1);
    localparam int PW = $clog2(PROGRAM_DEPTH + 1);

    typedef enum logic [6:0] {
        S_IDLE  = 7'b0000001,
        S_RD1   = 7'b0000010,
        S_RD2   = 7'b0000100,
        S_EXEC  = 7'b0001000,
        S_ALU   = 7'b0010000,
        S_WB    = 7'b0100000,
        S_OUT   = 7'b1000000
    } t_state;

    t_state       r_state;
    logic [7:0]   r_op;
    logic [31:0]  r_arg, r_rv;
    logic [SW-1:0] r_sp;
    logic [VW-1:0] r_vcnt;
    logic [PW-1:0] r_pc;
    logic         r_halt;
    logic [7:0]   r_code;
    logic [8:0]   r_plen;
    logic [31:0]  r_b, r_r;
    logic [2:0]   r_fault;
    logic         r_wvalid;
    logic [31:0]  r_wval;

    logic [31:0]  r_stk [STACK_DEPTH];
    logic [31:0]  r_var [VAR_DEPTH];
    logic [31:0]  r_stk_q, r_var_q;
    logic         s_we;
    logic [SA-1:0] s_waddr, s_raddr;
    logic [31:0]  s_wdata;
    logic         v_we;
    logic [VA-1:0] v_addr;

    t_alu_ctl     w_ctl;
    logic         w_alu_done;
    logic [31:0]  w_alu_res;

    logic [PW-1:0] w_eff;
    logic          w_finished;
    logic          w_vidx_ok, w_jmp_ok, w_binop, w_full;

    assign w_eff = (32'(r_plen) < PROGRAM_DEPTH) ? PW'(r_plen) : PW'(PROGRAM_DEPTH);
    assign w_finished = r_halt || (r_pc >= w_eff);
    assign w_vidx_ok  = !r_arg[31] && (r_arg < 32'(r_vcnt));
    assign w_jmp_ok   = !r_arg[31] && (r_arg <= 32'(w_eff));
    assign w_full     = (r_sp >= SW'(STACK_DEPTH));
    assign w_binop    = (r_op >= OP_ADD && r_op <= OP_PWR) ||
                        (r_op >= OP_LT && r_op <= OP_EQ);

    assign s_axis_tready = (r_state == S_IDLE);
    assign m_axis_tvalid = (r_state == S_OUT);
    assign m_axis_tdata  = {2'b00, r_fault, w_finished, r_code, r_halt,
                            r_pc[7:0], r_wval, r_wvalid};

    smeu_alu u_alu (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_ctl    (w_ctl),
        .i_a      (r_stk_q),
        .i_b      (r_b),
        .o_done   (w_alu_done),
        .o_result (w_alu_res)
    );

    always_comb begin
        w_ctl.start = (r_state == S_EXEC) && !w_finished && w_binop &&
                      r_sp >= SW'(2) &&
                      (r_op == OP_MULT || (r_op == OP_DIV && r_b != 32'd0) ||
                       (r_op == OP_PWR && !r_b[31]));
        w_ctl.op = (r_op == OP_MULT) ? ALU_MUL : (r_op == OP_DIV) ? ALU_DIV : ALU_PWR;
    end

    // stack memory
    always_ff @(posedge i_clk) begin
        if (s_we) r_stk[s_waddr] <= s_wdata;
        r_stk_q <= r_stk[s_raddr];
    end
    // variable memory
    always_ff @(posedge i_clk) begin
        if (v_we) r_var[v_addr] <= r_b;
        r_var_q <= r_var[v_addr];
    end

    assign v_addr = r_arg[VA-1:0];
    assign v_we   = (r_state == S_EXEC) && !w_finished && r_op == OP_STORE &&
                    r_sp != '0 && w_vidx_ok;

    always_comb begin
        s_raddr = SA'(r_sp - SW'(1));
        if (r_state == S_RD2) s_raddr = SA'(r_sp - SW'(2));
    end

    always_comb begin
        s_we    = 1'b0;
        s_waddr = SA'(r_sp);
        s_wdata = r_rv;
        if (r_state == S_EXEC && !w_finished && !w_full) begin
            case (r_op)
                OP_READ:   begin s_we = 1'b1; s_wdata = r_rv; end
                OP_LD_INT: begin s_we = 1'b1; s_wdata = r_arg; end
                default: ;
            endcase
        end
        if (r_state == S_WB && r_op == OP_LD_VAR) begin
            s_we = 1'b1; s_wdata = r_var_q;
        end
        if (r_state == S_WB && r_op != OP_LD_VAR) begin
            s_we = 1'b1; s_waddr = SA'(r_sp - SW'(2)); s_wdata = r_r;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
            r_sp    <= '0;
            r_vcnt  <= '0;
            r_pc    <= '0;
            r_halt  <= 1'b0;
            r_code  <= 8'd0;
            r_plen  <= 9'd1;
        end else begin
            if (i_cfg_we) r_plen <= i_cfg_wdata;
            unique case (r_state)
                S_IDLE: begin
                    if (s_axis_tvalid) begin
                        r_op     <= s_axis_tdata[7:0];
                        r_arg    <= s_axis_tdata[39:8];
                        r_rv     <= s_axis_tdata[71:40];
                        r_fault  <= FLT_NONE;
                        r_wvalid <= 1'b0;
                        r_wval   <= 32'd0;
                        r_state  <= S_RD1;
                    end
                end
                S_RD1: r_state <= S_RD2;
                S_RD2: begin
                    r_b <= r_stk_q;
                    r_state <= S_EXEC;
                end
                S_EXEC: begin
                    r_state <= S_OUT;
                    if (!w_finished) begin
                        r_pc <= r_pc + PW'(1);
                        if (w_binop) begin
                            if (r_sp < SW'(2)) begin
                                r_fault <= FLT_UNDERFLOW;
                            end else begin
                                unique case (r_op)
                                    OP_ADD: begin r_r <= r_stk_q + r_b; r_state <= S_WB; end
                                    OP_SUB: begin r_r <= r_stk_q - r_b; r_state <= S_WB; end
                                    OP_LT: begin
                                        r_r <= {31'd0, $signed(r_stk_q) < $signed(r_b)};
                                        r_state <= S_WB;
                                    end
                                    OP_GT: begin
                                        r_r <= {31'd0, $signed(r_stk_q) > $signed(r_b)};
                                        r_state <= S_WB;
                                    end
                                    OP_EQ: begin
                                        r_r <= {31'd0, r_stk_q == r_b};
                                        r_state <= S_WB;
                                    end
                                    OP_MULT: r_state <= S_ALU;
                                    OP_DIV: begin
                                        if (r_b == 32'd0) r_fault <= FLT_DIV_ZERO;
                                        else r_state <= S_ALU;
                                    end
                                    default: begin
                                        if (!r_b[31]) r_state <= S_ALU;
                                        else if (r_stk_q == 32'd0) r_fault <= FLT_DIV_ZERO;
                                        else begin
                                            r_state <= S_WB;
                                            if (r_stk_q == 32'd1) r_r <= 32'd1;
                                            else if (r_stk_q == 32'hFFFF_FFFF)
                                                r_r <= r_b[0] ? 32'hFFFF_FFFF : 32'd1;
                                            else r_r <= 32'd0;
                                        end
                                    end
                                endcase
                            end
                        end else begin
                            case (r_op)
                                OP_DATA: begin
                                    if (r_arg[31] || r_arg > 32'(VAR_DEPTH))
                                        r_fault <= FLT_BAD_VAR;
                                    else r_vcnt <= VW'(r_arg);
                                end
                                OP_HALT: begin
                                    r_halt <= 1'b1;
                                    r_code <= r_arg[7:0];
                                end
                                OP_READ, OP_LD_INT: begin
                                    if (w_full) r_fault <= FLT_OVERFLOW;
                                    else r_sp <= r_sp + SW'(1);
                                end
                                OP_WRITE: begin
                                    if (r_sp == '0) r_fault <= FLT_UNDERFLOW;
                                    else begin
                                        r_sp <= r_sp - SW'(1);
                                        r_wvalid <= 1'b1;
                                        r_wval <= r_b;
                                    end
                                end
                                OP_STORE: begin
                                    if (r_sp == '0) r_fault <= FLT_UNDERFLOW;
                                    else if (!w_vidx_ok) r_fault <= FLT_BAD_VAR;
                                    else r_sp <= r_sp - SW'(1);
                                end
                                OP_LD_VAR: begin
                                    if (w_full) r_fault <= FLT_OVERFLOW;
                                    else if (!w_vidx_ok) r_fault <= FLT_BAD_VAR;
                                    else r_state <= S_WB;
                                end
                                OP_JMP_FALSE: begin
                                    if (r_sp == '0) r_fault <= FLT_UNDERFLOW;
                                    else if (r_b != 32'd0) r_sp <= r_sp - SW'(1);
                                    else if (!w_jmp_ok) r_fault <= FLT_BAD_JUMP;
                                    else begin
                                        r_sp <= r_sp - SW'(1);
                                        r_pc <= PW'(r_arg);
                                    end
                                end
                                OP_GOTO: begin
                                    if (!w_jmp_ok) r_fault <= FLT_BAD_JUMP;
                                    else r_pc <= PW'(r_arg);
                                end
                                default: ;
                            endcase
                        end
                    end
                end
                S_ALU: begin
                    if (w_alu_done) begin
                        r_r <= w_alu_res;
                        r_state <= S_WB;
                    end
                end
                S_WB: begin
                    if (r_op == OP_LD_VAR) r_sp <= r_sp + SW'(1);
                    else r_sp <= r_sp - SW'(1);
                    r_state <= S_OUT;
                end
                S_OUT: begin
                    if (m_axis_tready) r_state <= S_IDLE;
                end
                default: r_state <= S_IDLE;
            endcase
        end
    end

    property p_sp_range;
        @(posedge i_clk) disable iff (!i_rst_n) r_sp <= SW'(STACK_DEPTH);
    endproperty
    a_sp_range: assert property (p_sp_range) else $error("stack pointer out of range");

    property p_fault_no_write;
        @(posedge i_clk) disable iff (!i_rst_n)
            (r_state == S_OUT && r_fault != FLT_NONE) |-> !r_wvalid;
    endproperty
    a_fault_no_write: assert property (p_fault_no_write) else $error("write on fault");

    property p_halt_sticky;
        @(posedge i_clk) disable iff (!i_rst_n) r_halt |=> r_halt;
    endproperty
    a_halt_sticky: assert property (p_halt_sticky) else $error("halt flag cleared");

    property p_alu_when_busy;
        @(posedge i_clk) disable iff (!i_rst_n) w_alu_done |-> r_state == S_ALU;
    endproperty
    a_alu_when_busy: assert property (p_alu_when_busy) else $error("stray alu done");

endmodule
